[hw/rtl/afu_pkg.sv]
`default_nettype none

package afu_pkg;

  // Activation selected by the mode register.
  typedef enum logic [1:0] {
    MODE_RELU  = 2'd0,
    MODE_GELU  = 2'd1,
    MODE_SWISH = 2'd2,
    MODE_PASS  = 2'd3
  } mode_e;

  // Control that travels with every sample through the pipeline.
  typedef struct packed {
    mode_e mode;
    logic  last;
  } ctl_t;

  localparam int MODE_W    = 2;
  localparam int ARG_W     = 22;       // Q16 argument, clamped to +-16.0
  localparam int ARG_LIMIT = 1 << 20;  // 16.0 in Q16
  localparam int SQ_W      = 25;       // a*a in Q16, never negative
  localparam int CUBE_W    = 30;       // a^3 in Q16
  localparam int K_W       = 25;       // cubic term times 0.044715
  localparam int SUM_W     = 26;       // a plus cubic term
  localparam int Z_W       = 27;       // sigmoid argument before clamping
  localparam int MAG_W     = 21;       // clamped magnitude, up to 16.0
  localparam int SIG_W     = 17;       // sigmoid in Q16, up to 1.0
  localparam int SEG_W     = 5;        // table segment index
  localparam int FRAC_W    = 15;       // position inside a segment
  localparam int SLOPE_W   = 13;
  localparam int SHIFT_Q16 = 16;
  localparam int ONE_Q16   = 65536;
  localparam int ROUND_HALF = 32768;

  localparam logic signed [13:0] CUBIC_Q16   = 14'sd2930;   // 0.044715
  localparam logic signed [17:0] SQRT2PI_Q16 = 18'sd52290;  // 0.7978845608

  // Sigmoid over [0,16) in steps of 0.5, Q16, and the rise to the next point.
  localparam logic [SIG_W-1:0] SIG_BASE [32] = '{
    17'd32768, 17'd40793, 17'd47911, 17'd53581, 17'd57724, 17'd60565, 17'd62428, 17'd63615,
    17'd64357, 17'd64816, 17'd65097, 17'd65269, 17'd65374, 17'd65438, 17'd65476, 17'd65500,
    17'd65514, 17'd65523, 17'd65528, 17'd65531, 17'd65533, 17'd65534, 17'd65535, 17'd65535,
    17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536
  };

  localparam logic [SLOPE_W-1:0] SIG_SLOPE [32] = '{
    13'd8025, 13'd7118, 13'd5670, 13'd4143, 13'd2841, 13'd1863, 13'd1187, 13'd742,
    13'd459,  13'd281,  13'd172,  13'd105,  13'd64,   13'd38,   13'd24,   13'd14,
    13'd9,    13'd5,    13'd3,    13'd2,    13'd1,    13'd1,    13'd0,    13'd1,
    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0
  };

endpackage

`default_nettype wire

[hw/rtl/afu_gelu_arg.sv]
`default_nettype none

// Converts the sample to a clamped Q16 argument and forms a + 0.044715*a^3
// over four stages (convert, square, cube, scale and add).
module afu_gelu_arg
  import afu_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire ctl_t                         ctl_i,
  input  wire logic signed [DATA_WIDTH-1:0] x_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output ctl_t                              ctl_o,
  output logic signed [DATA_WIDTH-1:0]      x_o,
  output logic signed [ARG_W-1:0]           a_o,
  output logic signed [SUM_W-1:0]           ak_o
);

  localparam int WIDE_W = DATA_WIDTH + SHIFT_Q16;
  localparam int SH_R   = (FRAC_BITS > SHIFT_Q16) ? FRAC_BITS - SHIFT_Q16 : 0;
  localparam int SH_L   = (FRAC_BITS < SHIFT_Q16) ? SHIFT_Q16 - FRAC_BITS : 0;
  localparam logic signed [WIDE_W-1:0] LIM_HI = WIDE_W'(ARG_LIMIT);
  localparam logic signed [WIDE_W-1:0] LIM_LO = -LIM_HI;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic signed [DATA_WIDTH-1:0] x1_q, x2_q, x3_q, x4_q;
  logic signed [ARG_W-1:0] a1_q, a2_q, a3_q, a4_q;
  logic signed [ARG_W-1:0] a_d;
  logic signed [WIDE_W-1:0] x_wide, a_wide;
  logic signed [2*ARG_W-1:0] sq;
  logic [SQ_W-1:0] c_d, c2_q;
  logic signed [SQ_W+ARG_W:0] cube;
  logic signed [CUBE_W-1:0] t_d, t3_q;
  logic signed [CUBE_W+13:0] kp;
  logic signed [K_W-1:0] k;
  logic signed [SUM_W-1:0] ak_d, ak4_q;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    x_wide = {{SHIFT_Q16{x_i[DATA_WIDTH-1]}}, x_i};
    a_wide = (x_wide >>> SH_R) <<< SH_L;
    if (a_wide > LIM_HI) begin
      a_d = LIM_HI[ARG_W-1:0];
    end else if (a_wide < LIM_LO) begin
      a_d = LIM_LO[ARG_W-1:0];
    end else begin
      a_d = a_wide[ARG_W-1:0];
    end
  end

  assign sq   = a1_q * a1_q;
  assign c_d  = sq[SHIFT_Q16+SQ_W-1:SHIFT_Q16];
  assign cube = $signed({1'b0, c2_q}) * a2_q;
  assign t_d  = cube[SHIFT_Q16+CUBE_W-1:SHIFT_Q16];
  assign kp   = t3_q * CUBIC_Q16;
  assign k    = kp[SHIFT_Q16+K_W-1:SHIFT_Q16];
  assign ak_d = {{(SUM_W-ARG_W){a3_q[ARG_W-1]}}, a3_q} + {{(SUM_W-K_W){k[K_W-1]}}, k};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ctl1_q <= ctl_i;
      x1_q   <= x_i;
      a1_q   <= a_d;
    end
    if (en2) begin
      ctl2_q <= ctl1_q;
      x2_q   <= x1_q;
      a2_q   <= a1_q;
      c2_q   <= c_d;
    end
    if (en3) begin
      ctl3_q <= ctl2_q;
      x3_q   <= x2_q;
      a3_q   <= a2_q;
      t3_q   <= t_d;
    end
    if (en4) begin
      ctl4_q <= ctl3_q;
      x4_q   <= x3_q;
      a4_q   <= a3_q;
      ak4_q  <= ak_d;
    end
  end

  assign valid_o = v4_q;
  assign ctl_o   = ctl4_q;
  assign x_o     = x4_q;
  assign a_o     = a4_q;
  assign ak_o    = ak4_q;

  a_arg_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (a1_q <= ARG_LIMIT && a1_q >= -ARG_LIMIT))
    else $error("Q16 argument escaped the +-16.0 clamp.");

endmodule

`default_nettype wire

[hw/rtl/afu_sigmoid.sv]
`default_nettype none

// Picks the sigmoid argument (2u for GELU, a for Swish), clamps it, and
// interpolates the mirrored sigmoid table over two stages.
module afu_sigmoid
  import afu_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire ctl_t                         ctl_i,
  input  wire logic signed [DATA_WIDTH-1:0] x_i,
  input  wire logic signed [ARG_W-1:0]      a_i,
  input  wire logic signed [SUM_W-1:0]      ak_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output ctl_t                              ctl_o,
  output logic signed [DATA_WIDTH-1:0]      x_o,
  output logic [SIG_W-1:0]                  s_o
);

  logic v5_q, v6_q;
  logic en5, en6;
  ctl_t ctl5_q, ctl6_q;
  logic signed [DATA_WIDTH-1:0] x5_q, x6_q;
  logic signed [SUM_W+17:0] up;
  logic signed [SUM_W-1:0] u;
  logic signed [Z_W-1:0] z;
  logic [Z_W-1:0] z_abs;
  logic neg_d, neg5_q;
  logic [MAG_W-1:0] m_d, m5_q;
  logic [SEG_W-1:0] idx;
  logic [FRAC_W-1:0] frac;
  logic [SLOPE_W+FRAC_W-1:0] rise;
  logic [SIG_W-1:0] sp, s_d, s6_q;

  assign en6     = !v6_q || ready_i;
  assign en5     = !v5_q || en6;
  assign ready_o = en5;

  always_comb begin
    up = ak_i * SQRT2PI_Q16;
    u  = up[SHIFT_Q16+SUM_W-1:SHIFT_Q16];
    if (ctl_i.mode == MODE_GELU) begin
      z = {u, 1'b0};
    end else begin
      z = {{(Z_W-ARG_W){a_i[ARG_W-1]}}, a_i};
    end
    neg_d = z[Z_W-1];
    z_abs = neg_d ? -z : z;
    if (z_abs >= Z_W'(ARG_LIMIT)) begin
      m_d = MAG_W'(ARG_LIMIT);
    end else begin
      m_d = z_abs[MAG_W-1:0];
    end
  end

  // Saturated magnitudes read as exactly one; the negative side mirrors.
  always_comb begin
    idx  = m5_q[SEG_W+FRAC_W-1:FRAC_W];
    frac = m5_q[FRAC_W-1:0];
    rise = SIG_SLOPE[idx] * frac;
    if (m5_q[MAG_W-1]) begin
      sp = SIG_W'(ONE_Q16);
    end else begin
      sp = SIG_BASE[idx] + SIG_W'(rise[SLOPE_W+FRAC_W-1:FRAC_W]);
    end
    s_d = neg5_q ? SIG_W'(ONE_Q16) - sp : sp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      ctl5_q <= ctl_i;
      x5_q   <= x_i;
      neg5_q <= neg_d;
      m5_q   <= m_d;
    end
    if (en6) begin
      ctl6_q <= ctl5_q;
      x6_q   <= x5_q;
      s6_q   <= s_d;
    end
  end

  assign valid_o = v6_q;
  assign ctl_o   = ctl6_q;
  assign x_o     = x6_q;
  assign s_o     = s6_q;

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> (s6_q <= SIG_W'(ONE_Q16)))
    else $error("Sigmoid gain above one.");

endmodule

`default_nettype wire

[hw/rtl/afu_scale.sv]
`default_nettype none

// Multiplies the sample by the Q16 gain, rounds, saturates and selects the
// result for the mode. The second stage is the output register.
module afu_scale
  import afu_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire ctl_t                         ctl_i,
  input  wire logic signed [DATA_WIDTH-1:0] x_i,
  input  wire logic [SIG_W-1:0]             s_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output logic signed [DATA_WIDTH-1:0]      act_o,
  output logic                              last_o
);

  localparam int PW = DATA_WIDTH + SIG_W + 2;
  localparam int RW = PW - SHIFT_Q16;

  logic v7_q, v8_q;
  logic en7, en8;
  ctl_t ctl7_q, ctl8_q;
  logic signed [DATA_WIDTH-1:0] x7_q;
  logic signed [DATA_WIDTH+SIG_W:0] mul;
  logic signed [PW-1:0] prod_d, prod7_q;
  logic signed [RW-1:0] r;
  logic [RW-DATA_WIDTH:0] top_bits;
  logic signed [DATA_WIDTH-1:0] sat, act_d, act_q;

  assign en8     = !v8_q || ready_i;
  assign en7     = !v7_q || en8;
  assign ready_o = en7;

  assign mul    = x_i * $signed({1'b0, s_i});
  assign prod_d = PW'(mul) + PW'(ROUND_HALF);

  always_comb begin
    r        = prod7_q[PW-1:SHIFT_Q16];
    top_bits = r[RW-1:DATA_WIDTH-1];
    if ((&top_bits) || !(|top_bits)) begin
      sat = r[DATA_WIDTH-1:0];
    end else if (r[RW-1]) begin
      sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    unique case (ctl7_q.mode)
      MODE_RELU:             act_d = x7_q[DATA_WIDTH-1] ? '0 : x7_q;
      MODE_GELU, MODE_SWISH: act_d = sat;
      MODE_PASS:             act_d = x7_q;
      default:               act_d = x7_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (en7) v7_q <= valid_i;
      if (en8) v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7) begin
      ctl7_q  <= ctl_i;
      x7_q    <= x_i;
      prod7_q <= prod_d;
    end
    if (en8) begin
      ctl8_q <= ctl7_q;
      act_q  <= act_d;
    end
  end

  assign valid_o = v8_q;
  assign act_o   = act_q;
  assign last_o  = ctl8_q.last;

  a_relu_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v8_q && ctl8_q.mode == MODE_RELU) |-> !act_q[DATA_WIDTH-1])
    else $error("ReLU produced a negative result.");

  a_pass_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && en8 && ctl7_q.mode == MODE_PASS) |=> (act_q == $past(x7_q)))
    else $error("Pass-through result differs from its sample.");

endmodule

`default_nettype wire

[hw/rtl/activation_function_unit.sv]
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: sample; tlast: last_in
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: activated; tlast: last_out
// cfg       in         cfg_we_i                      cfg_wdata_i: mode
//
// One transaction is taken per clock cycle while s_axis_tready is high. Eight register stages
// (convert, square, cube, cubic add, argument clamp, table, multiply, output) carry each
// accepted sample in that order into the output register, from which its result leaves.
// Reset clears every stage valid bit and sets the mode to ReLU.
// A stall on m_axis fills empty stages first; s_axis_tready drops only when
// every stage holds a sample, and nothing is dropped or repeated.
`default_nettype none

module activation_function_unit
  import afu_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 11,
  localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Mode register write port.
  input  wire logic               cfg_we_i,
  input  wire logic [MODE_W-1:0]  cfg_wdata_i,
  // Input stream.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [DATA_WIDTH-1:0] sample, rest zero
  input  wire logic               s_axis_tlast,
  // Output stream.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // [DATA_WIDTH-1:0] activated, rest zero
  output logic                    m_axis_tlast
);

  // The mode is captured with each sample, so it rides along with the data
  // through the pipeline in the control struct.
  mode_e mode_q;

  ctl_t in_ctl;
  logic signed [DATA_WIDTH-1:0] in_x;

  logic arg_valid, arg_ready;
  ctl_t arg_ctl;
  logic signed [DATA_WIDTH-1:0] arg_x;
  logic signed [ARG_W-1:0] arg_a;
  logic signed [SUM_W-1:0] arg_ak;

  logic sig_valid, sig_ready;
  ctl_t sig_ctl;
  logic signed [DATA_WIDTH-1:0] sig_x;
  logic [SIG_W-1:0] sig_s;

  logic signed [DATA_WIDTH-1:0] act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RELU;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  assign in_x   = s_axis_tdata[DATA_WIDTH-1:0];
  assign in_ctl = '{mode: mode_q, last: s_axis_tlast};

  // GELU argument: clamped Q16 sample and a + 0.044715*a^3.
  afu_gelu_arg #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_gelu_arg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .ctl_i   (in_ctl),
    .x_i     (in_x),
    .valid_o (arg_valid),
    .ready_i (arg_ready),
    .ctl_o   (arg_ctl),
    .x_o     (arg_x),
    .a_o     (arg_a),
    .ak_o    (arg_ak)
  );

  // Sigmoid gain; GELU uses 0.5*(1+tanh(u)) = sigmoid(2u).
  afu_sigmoid #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sigmoid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (arg_valid),
    .ready_o (arg_ready),
    .ctl_i   (arg_ctl),
    .x_i     (arg_x),
    .a_i     (arg_a),
    .ak_i    (arg_ak),
    .valid_o (sig_valid),
    .ready_i (sig_ready),
    .ctl_o   (sig_ctl),
    .x_o     (sig_x),
    .s_o     (sig_s)
  );

  // Gain multiply, rounding, saturation and the output register.
  afu_scale #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sig_valid),
    .ready_o (sig_ready),
    .ctl_i   (sig_ctl),
    .x_i     (sig_x),
    .s_i     (sig_s),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .act_o   (act),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'($unsigned(act));

endmodule

`default_nettype wire
